// ===== rtl/rau_pkg.sv =====
// shared types, constants and codes for the rational arithmetic unit
// no dependencies; imported by rau_ctrl, rau_dp and rational_arithmetic_unit
package rau_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAG_W      = 2 * VALUE_BITS;
    localparam int SHIFT_W    = $clog2(MAG_W + 1);
    localparam int FIELD_W    = 32;
    localparam int DEN_W      = 31;

    localparam logic [MAG_W-1:0] LIMIT_POS =
        {{(MAG_W - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
    localparam logic [MAG_W-1:0] LIMIT_NEG = LIMIT_POS + MAG_W'(1);

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_DEN  = 2'd1,
        ST_DIV_ZERO  = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    // which fraction the shared reduction works on
    typedef enum logic [1:0] {
        SEL_LEFT   = 2'd0,
        SEL_RIGHT  = 2'd1,
        SEL_RESULT = 2'd2
    } red_sel_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD_IN,
        OP_RED_LOAD,
        OP_GCD_STEP,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_RED_STORE,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_COMBINE,
        OP_LOAD_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RED_LOAD,
        S_GCD,
        S_DIV_LOAD,
        S_DIV,
        S_RED_STORE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMBINE,
        S_FINAL,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t   op;
        red_sel_t sel;
        status_t  status;
    } dp_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic div_zero;
        logic red_zero;
        logic gcd_done;
        logic div_done;
        logic overflow;
    } dp_flags_t;

endpackage

// ===== rtl/rau_ctrl.sv =====
// sequencer for the rational arithmetic unit: handshakes and step order
// depends on rau_pkg; drives rau_dp through command and flag structs
module rau_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rau_pkg::dp_flags_t flags,
    output rau_pkg::dp_cmd_t  cmd
);
    import rau_pkg::*;

    ctrl_state_t state_reg, state_next;
    red_sel_t    sel_reg, sel_next;
    status_t     status_reg, status_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= SEL_LEFT;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (flags.den_zero)
                begin
                    status_next = ST_ZERO_DEN;
                    state_next  = S_OUT;
                end
                else
                begin
                    sel_next   = SEL_LEFT;
                    state_next = S_RED_LOAD;
                end
            end
            S_RED_LOAD:  state_next = S_GCD;
            S_GCD:
            begin
                if (flags.red_zero)
                    state_next = S_RED_STORE;
                else if (flags.gcd_done)
                    state_next = S_DIV_LOAD;
            end
            S_DIV_LOAD:  state_next = S_DIV;
            S_DIV:
            begin
                if (flags.div_done)
                    state_next = S_RED_STORE;
            end
            S_RED_STORE:
            begin
                case (sel_reg)
                    SEL_LEFT:
                    begin
                        sel_next   = SEL_RIGHT;
                        state_next = S_RED_LOAD;
                    end
                    SEL_RIGHT:   state_next = S_MUL0;
                    default:     state_next = S_FINAL;
                endcase
            end
            S_MUL0:
            begin
                if (flags.div_zero)
                begin
                    status_next = ST_DIV_ZERO;
                    state_next  = S_OUT;
                end
                else
                    state_next = S_MUL1;
            end
            S_MUL1:      state_next = S_MUL2;
            S_MUL2:      state_next = S_COMBINE;
            S_COMBINE:
            begin
                sel_next   = SEL_RESULT;
                state_next = S_RED_LOAD;
            end
            S_FINAL:
            begin
                status_next = flags.overflow ? ST_OVERFLOW : ST_OK;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op         = OP_NOP;
        cmd.sel        = sel_reg;
        cmd.status     = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:      if (in_valid) cmd.op = OP_LOAD_IN;
            S_RED_LOAD:  cmd.op = OP_RED_LOAD;
            S_GCD:       if (!flags.red_zero && !flags.gcd_done) cmd.op = OP_GCD_STEP;
            S_DIV_LOAD:  cmd.op = OP_DIV_LOAD;
            S_DIV:       if (!flags.div_done) cmd.op = OP_DIV_STEP;
            S_RED_STORE: cmd.op = OP_RED_STORE;
            S_MUL0:      cmd.op = OP_MUL0;
            S_MUL1:      cmd.op = OP_MUL1;
            S_MUL2:      cmd.op = OP_MUL2;
            S_COMBINE:   cmd.op = OP_COMBINE;
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.op         = OP_LOAD_OUT;
                    out_valid_next = 1'b1;
                end
            end
            default:     cmd.op = OP_NOP;
        endcase
    end

endmodule

// ===== rtl/rau_dp.sv =====
// datapath: operand store, binary gcd, restoring divider, multiplier, result register
// depends on rau_pkg; steered by rau_ctrl
module rau_dp (
    input  logic                         clk,
    input  rau_pkg::dp_cmd_t             cmd,
    output rau_pkg::dp_flags_t           flags,
    input  logic [1:0]                   in_kind,
    input  logic signed [rau_pkg::FIELD_W-1:0] in_left_num,
    input  logic signed [rau_pkg::FIELD_W-1:0] in_left_den,
    input  logic signed [rau_pkg::FIELD_W-1:0] in_right_num,
    input  logic signed [rau_pkg::FIELD_W-1:0] in_right_den,
    output logic signed [rau_pkg::FIELD_W-1:0] result_num,
    output logic [rau_pkg::DEN_W-1:0]    result_den,
    output logic [1:0]                   status
);
    import rau_pkg::*;

    localparam int VB = VALUE_BITS;

    // operands, sign-magnitude
    kind_t           kind_reg;
    logic [VB-1:0]   n1_reg, d1_reg, n2_reg, d2_reg;
    logic            s1_reg, s2_reg;
    // products and result
    logic [MAG_W-1:0] t1_reg, t2_reg, rn_reg, rd_reg;
    logic             rneg_reg;
    // reduction unit
    logic [MAG_W-1:0] x_reg, y_reg, u_reg, v_reg, g_reg, dx_reg, dy_reg, rx_reg, ry_reg;
    logic [SHIFT_W-1:0] k_reg, cnt_reg;
    // output register
    logic signed [FIELD_W-1:0] out_num_reg;
    logic [DEN_W-1:0]          out_den_reg;
    status_t                   out_st_reg;

    // input operand conversion
    logic [VB-1:0] ln_v, ld_v, rn_v, rd_v;
    logic [VB-1:0] ln_m, ld_m, rn_m, rd_m;

    assign ln_v = in_left_num[VB-1:0];
    assign ld_v = in_left_den[VB-1:0];
    assign rn_v = in_right_num[VB-1:0];
    assign rd_v = in_right_den[VB-1:0];
    assign ln_m = ln_v[VB-1] ? (~ln_v + VB'(1)) : ln_v;
    assign ld_m = ld_v[VB-1] ? (~ld_v + VB'(1)) : ld_v;
    assign rn_m = rn_v[VB-1] ? (~rn_v + VB'(1)) : rn_v;
    assign rd_m = rd_v[VB-1] ? (~rd_v + VB'(1)) : rd_v;

    // binary gcd step
    logic [MAG_W-1:0]   u_next, v_next;
    logic [SHIFT_W-1:0] k_next;

    always_comb
    begin
        u_next = u_reg;
        v_next = v_reg;
        k_next = k_reg;
        if (!u_reg[0] && !v_reg[0])
        begin
            u_next = u_reg >> 1;
            v_next = v_reg >> 1;
            k_next = k_reg + SHIFT_W'(1);
        end
        else if (!u_reg[0])
            u_next = u_reg >> 1;
        else if (!v_reg[0])
            v_next = v_reg >> 1;
        else if (u_reg >= v_reg)
            u_next = u_reg - v_reg;
        else
            v_next = v_reg - u_reg;
    end

    // restoring divider step, two dividends against one divisor
    logic [MAG_W:0]   rx_sh, ry_sh;
    logic             qx_bit, qy_bit;
    logic [MAG_W-1:0] rx_next, ry_next;

    always_comb
    begin
        rx_sh   = {rx_reg, dx_reg[MAG_W-1]};
        ry_sh   = {ry_reg, dy_reg[MAG_W-1]};
        qx_bit  = (rx_sh >= {1'b0, g_reg});
        qy_bit  = (ry_sh >= {1'b0, g_reg});
        rx_next = qx_bit ? MAG_W'(rx_sh - {1'b0, g_reg}) : rx_sh[MAG_W-1:0];
        ry_next = qy_bit ? MAG_W'(ry_sh - {1'b0, g_reg}) : ry_sh[MAG_W-1:0];
    end

    // shared multiplier
    logic [VB-1:0]    mul_a, mul_b;
    logic [MAG_W-1:0] product;

    always_comb
    begin
        case (cmd.op)
            OP_MUL0:
            begin
                mul_a = n1_reg;
                mul_b = (kind_reg == KIND_MUL) ? n2_reg : d2_reg;
            end
            OP_MUL1:
            begin
                mul_a = n2_reg;
                mul_b = d1_reg;
            end
            default:
            begin
                mul_a = d1_reg;
                mul_b = (kind_reg == KIND_DIV) ? n2_reg : d2_reg;
            end
        endcase
        product = MAG_W'(mul_a) * MAG_W'(mul_b);
    end

    // signed add or subtract of the cross products; multiply and divide pass the first product through
    logic             g1, g2;
    logic [MAG_W-1:0] comb_mag;
    logic             comb_neg;

    always_comb
    begin
        g1 = s1_reg && (t1_reg != '0);
        g2 = ((kind_reg == KIND_SUB) ? !s2_reg : s2_reg) && (t2_reg != '0);
        if (kind_reg == KIND_ADD || kind_reg == KIND_SUB)
        begin
            if (g1 == g2)
            begin
                comb_mag = t1_reg + t2_reg;
                comb_neg = g1;
            end
            else if (t1_reg >= t2_reg)
            begin
                comb_mag = t1_reg - t2_reg;
                comb_neg = g1;
            end
            else
            begin
                comb_mag = t2_reg - t1_reg;
                comb_neg = g2;
            end
        end
        else
        begin
            comb_mag = t1_reg;
            comb_neg = s1_reg ^ s2_reg;
        end
    end

    // result formatting
    logic signed [MAG_W-1:0] num_twos;
    assign num_twos = rneg_reg ? signed'(-rn_reg) : signed'(rn_reg);

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD_IN:
            begin
                kind_reg <= kind_t'(in_kind);
                n1_reg   <= ln_m;
                d1_reg   <= ld_m;
                n2_reg   <= rn_m;
                d2_reg   <= rd_m;
                s1_reg   <= ln_v[VB-1] ^ ld_v[VB-1];
                s2_reg   <= rn_v[VB-1] ^ rd_v[VB-1];
            end
            OP_RED_LOAD:
            begin
                case (cmd.sel)
                    SEL_LEFT:
                    begin
                        x_reg <= MAG_W'(n1_reg);
                        y_reg <= MAG_W'(d1_reg);
                        u_reg <= MAG_W'(n1_reg);
                        v_reg <= MAG_W'(d1_reg);
                    end
                    SEL_RIGHT:
                    begin
                        x_reg <= MAG_W'(n2_reg);
                        y_reg <= MAG_W'(d2_reg);
                        u_reg <= MAG_W'(n2_reg);
                        v_reg <= MAG_W'(d2_reg);
                    end
                    default:
                    begin
                        x_reg <= rn_reg;
                        y_reg <= rd_reg;
                        u_reg <= rn_reg;
                        v_reg <= rd_reg;
                    end
                endcase
                k_reg <= '0;
            end
            OP_GCD_STEP:
            begin
                u_reg <= u_next;
                v_reg <= v_next;
                k_reg <= k_next;
            end
            OP_DIV_LOAD:
            begin
                g_reg   <= (u_reg | v_reg) << k_reg;
                dx_reg  <= x_reg;
                dy_reg  <= y_reg;
                rx_reg  <= '0;
                ry_reg  <= '0;
                cnt_reg <= SHIFT_W'(MAG_W);
            end
            OP_DIV_STEP:
            begin
                rx_reg  <= rx_next;
                ry_reg  <= ry_next;
                dx_reg  <= {dx_reg[MAG_W-2:0], qx_bit};
                dy_reg  <= {dy_reg[MAG_W-2:0], qy_bit};
                cnt_reg <= cnt_reg - SHIFT_W'(1);
            end
            OP_RED_STORE:
            begin
                // zero numerator reduces to 0/1 with positive sign
                case (cmd.sel)
                    SEL_LEFT:
                    begin
                        n1_reg <= flags.red_zero ? '0 : dx_reg[VB-1:0];
                        d1_reg <= flags.red_zero ? VB'(1) : dy_reg[VB-1:0];
                        if (flags.red_zero)
                            s1_reg <= 1'b0;
                    end
                    SEL_RIGHT:
                    begin
                        n2_reg <= flags.red_zero ? '0 : dx_reg[VB-1:0];
                        d2_reg <= flags.red_zero ? VB'(1) : dy_reg[VB-1:0];
                        if (flags.red_zero)
                            s2_reg <= 1'b0;
                    end
                    default:
                    begin
                        rn_reg <= flags.red_zero ? '0 : dx_reg;
                        rd_reg <= flags.red_zero ? MAG_W'(1) : dy_reg;
                        if (flags.red_zero)
                            rneg_reg <= 1'b0;
                    end
                endcase
            end
            OP_MUL0:    t1_reg <= product;
            OP_MUL1:    t2_reg <= product;
            OP_MUL2:    rd_reg <= product;
            OP_COMBINE:
            begin
                rn_reg   <= comb_mag;
                rneg_reg <= comb_neg;
            end
            OP_LOAD_OUT:
            begin
                out_st_reg <= cmd.status;
                if (cmd.status == ST_OK)
                begin
                    out_num_reg <= FIELD_W'(num_twos);
                    out_den_reg <= DEN_W'(rd_reg);
                end
                else
                begin
                    out_num_reg <= '0;
                    out_den_reg <= '0;
                end
            end
            default: ;
        endcase
    end

    assign flags.den_zero = (d1_reg == '0) || (d2_reg == '0);
    assign flags.div_zero = (kind_reg == KIND_DIV) && (n2_reg == '0);
    assign flags.red_zero = (x_reg == '0);
    assign flags.gcd_done = (u_reg == '0) || (v_reg == '0);
    assign flags.div_done = (cnt_reg == '0);
    assign flags.overflow = (rd_reg > LIMIT_POS) ||
                            (rneg_reg ? (rn_reg > LIMIT_NEG) : (rn_reg > LIMIT_POS));

    assign result_num = out_num_reg;
    assign result_den = out_den_reg;
    assign status     = out_st_reg;

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// top level of the rational arithmetic unit: stream ports, controller and datapath
// depends on rau_pkg, rau_ctrl and rau_dp
//
// adds, subtracts, multiplies or divides two signed fractions and returns the
// result in lowest terms with a positive denominator and a status code
// (ok, zero input denominator, division by zero, overflow). one item is
// processed at a time; the result sits in an output register, so a new
// transaction is taken as soon as the sequencer is back in idle even if the
// previous result has not been taken yet. most of the work is done by the
// shared reduction unit, which runs up to three times per item (left
// operand, right operand, result). each run is a load step, then a binary gcd
// loop of one subtract or shift per cycle, then forming the divisor, then a
// restoring divider that divides numerator and denominator together, then a
// store step. the multiply steps mul0, mul1 and mul2 and the combine step
// come between the operand runs and the result run. a zero numerator skips
// its gcd and divide. a zero input denominator is caught in the check state
// and goes straight to the output state without any reduction.
module rational_arithmetic_unit (
    input  logic         clk,
    input  logic         rst_n,
    // input operands
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // left_num, left_den, right_num, right_den
    input  logic [1:0]   s_tuser,  // kind
    // result
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,  // result_num, result_den, zero pad
    output logic [1:0]   m_tuser   // status
);
    import rau_pkg::*;

    dp_cmd_t   cmd;
    dp_flags_t flags;

    logic signed [FIELD_W-1:0] result_num;
    logic [DEN_W-1:0]          result_den;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .flags     (flags),
        .cmd       (cmd)
    );

    rau_dp u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .flags        (flags),
        .in_kind      (s_tuser),
        .in_left_num  (s_tdata[31:0]),
        .in_left_den  (s_tdata[63:32]),
        .in_right_num (s_tdata[95:64]),
        .in_right_den (s_tdata[127:96]),
        .result_num   (result_num),
        .result_den   (result_den),
        .status       (m_tuser)
    );

    // pack the result, numerator in the low word
    assign m_tdata = {1'b0, result_den, result_num};

endmodule
